>>> design/ivu_pkg.sv
package ivu_pkg;

    // opcodes of one request
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_RX     = 3'd1,
        OP_ALLOC  = 3'd2,
        OP_LOAD   = 3'd3,
        OP_TOGGLE = 3'd4
    } t_opcode;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MIN_HOURS       = 3'd0,
        CFG_HOURS_PER_TICK  = 3'd1,
        CFG_SEQ_LIMIT       = 3'd2,
        CFG_TEST_BYPASS     = 3'd3,
        CFG_PRIMARY_PRESENT = 3'd4
    } t_cfg_index;

    localparam int CFG_DATA_W = 24;

    localparam logic [7:0]  MIN_HOURS_RST       = 8'd96;
    localparam logic [7:0]  HOURS_PER_TICK_RST  = 8'd24;
    localparam logic [23:0] SEQ_LIMIT_RST       = 24'd8000000;
    localparam logic        TEST_BYPASS_RST     = 1'b0;
    localparam logic        PRIMARY_PRESENT_RST = 1'b1;

    localparam logic [31:0] RECOVERY_WINDOW = 32'd42;
    localparam logic [7:0]  HOURS_MAX       = 8'hFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] new_index;
        logic        update_flag;
        logic        tx_busy;
        logic [7:0]  load_hours;
        logic [23:0] load_seq;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [23:0] seq_out;
        logic [31:0] index_now;
        logic        in_progress;
        logic        replay_clear;
        logic        replay_reset;
        logic        initiator_mark;
        logic        deferred;
        logic        state_changed;
        logic        timer_on;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  min_hours;
        logic [7:0]  hours_per_tick;
        logic [23:0] seq_limit;
        logic        test_bypass;
        logic        primary_present;
    } t_cfg;

endpackage

>>> design/ivu_cfg_regs.sv
module ivu_cfg_regs
    import ivu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_hours       <= MIN_HOURS_RST;
            r_cfg.hours_per_tick  <= HOURS_PER_TICK_RST;
            r_cfg.seq_limit       <= SEQ_LIMIT_RST;
            r_cfg.test_bypass     <= TEST_BYPASS_RST;
            r_cfg.primary_present <= PRIMARY_PRESENT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_HOURS:       r_cfg.min_hours       <= i_cfg_data[7:0];
                CFG_HOURS_PER_TICK:  r_cfg.hours_per_tick  <= i_cfg_data[7:0];
                CFG_SEQ_LIMIT:       r_cfg.seq_limit       <= i_cfg_data[23:0];
                CFG_TEST_BYPASS:     r_cfg.test_bypass     <= i_cfg_data[0];
                CFG_PRIMARY_PRESENT: r_cfg.primary_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/ivu_core.sv
module ivu_core
    import ivu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [31:0] r_index, n_index;
    logic        r_active, n_active;
    logic [7:0]  r_hours, n_hours;
    logic [23:0] r_seq, n_seq;
    logic        r_timer, n_timer;

    // values after the opcode's own changes, before the update attempt
    logic [7:0]  m_hours;
    logic [23:0] m_seq;
    logic        m_timer;
    logic [8:0]  tick_sum;
    logic [23:0] seq_inc;

    logic        tu_go, tu_flag, tu_fail, tu_skip;
    logic [31:0] tu_idx, win_hi, idx_plus1;

    logic        f_acc, f_clear, f_reset, f_init, f_defer, f_changed;
    logic [23:0] seq_out;

    always_comb begin
        tick_sum  = {1'b0, r_hours} + {1'b0, i_cfg.hours_per_tick};
        seq_inc   = r_seq + 24'd1;
        idx_plus1 = r_index + 32'd1;
        win_hi    = r_index + RECOVERY_WINDOW;

        m_hours = r_hours;
        m_seq   = r_seq;
        m_timer = r_timer;
        tu_go   = 1'b0;
        tu_idx  = r_index;
        tu_flag = 1'b0;
        f_acc   = 1'b0;
        f_init  = 1'b0;
        n_index = r_index;
        n_active = r_active;

        case (i_item.opcode)
            OP_TICK: begin
                if (r_timer) begin
                    m_hours = tick_sum[8] ? HOURS_MAX : tick_sum[7:0];
                    m_timer = 1'b0;
                    if (m_hours < i_cfg.min_hours) begin
                        m_timer = 1'b1;
                    end else if (r_active) begin
                        f_init = 1'b1;
                        tu_go  = 1'b1;
                    end
                end
            end
            OP_RX: begin
                tu_go   = 1'b1;
                tu_idx  = i_item.new_index;
                tu_flag = i_item.update_flag;
            end
            OP_ALLOC: begin
                m_seq = seq_inc;
                if (!r_active && (seq_inc > i_cfg.seq_limit) && i_cfg.primary_present) begin
                    f_init  = 1'b1;
                    tu_go   = 1'b1;
                    tu_idx  = idx_plus1;
                    tu_flag = 1'b1;
                end
            end
            OP_LOAD: begin
                n_index  = i_item.new_index;
                n_active = i_item.update_flag;
                m_hours  = i_item.load_hours;
                m_seq    = i_item.load_seq;
                if (i_item.load_hours < i_cfg.min_hours) begin
                    m_timer = 1'b1;
                end
                f_acc = 1'b1;
            end
            OP_TOGGLE: begin
                tu_go = 1'b1;
                if (!r_active) begin
                    tu_idx  = idx_plus1;
                    tu_flag = 1'b1;
                end
            end
            default: ;
        endcase

        n_hours   = m_hours;
        n_seq     = m_seq;
        n_timer   = m_timer;
        f_clear   = 1'b0;
        f_reset   = 1'b0;
        f_defer   = 1'b0;
        f_changed = 1'b0;
        tu_fail   = 1'b0;
        tu_skip   = 1'b0;

        // update attempt: normal-mode, in-progress and recovery rules
        if (tu_go) begin
            if (r_active) begin
                if ((tu_idx != r_index) || tu_flag) begin
                    tu_fail = 1'b1;
                end
            end else begin
                if (tu_idx == r_index) begin
                    tu_fail = 1'b1;
                end else if ((tu_idx < r_index) || (tu_idx > win_hi)) begin
                    tu_fail = 1'b1;
                end else if (tu_idx > idx_plus1) begin
                    // recovery jump inside the window
                    f_clear = 1'b1;
                    n_index = tu_idx;
                    n_seq   = 24'd0;
                    tu_skip = 1'b1;
                end else if (!tu_flag) begin
                    tu_fail = 1'b1;
                end
            end
            if (!tu_fail && !tu_skip) begin
                if (!i_cfg.test_bypass && (m_hours < i_cfg.min_hours)) begin
                    tu_fail = 1'b1;
                end else if (!tu_flag && i_item.tx_busy) begin
                    f_defer = 1'b1;
                    tu_fail = 1'b1;
                end
            end
            if (!tu_fail) begin
                n_active = tu_flag;
                n_hours  = 8'd0;
                if (tu_flag) begin
                    n_index = tu_idx;
                    f_reset = 1'b1;
                end else begin
                    n_seq = 24'd0;
                end
                n_timer   = 1'b1;
                f_changed = 1'b1;
                f_acc     = 1'b1;
            end
        end

        seq_out = (i_item.opcode == OP_ALLOC) ? r_seq : n_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index  <= '0;
            r_active <= 1'b0;
            r_hours  <= '0;
            r_seq    <= '0;
            r_timer  <= 1'b0;
        end else if (i_fire) begin
            r_index  <= n_index;
            r_active <= n_active;
            r_hours  <= n_hours;
            r_seq    <= n_seq;
            r_timer  <= n_timer;
        end
    end

    always_comb begin
        o_result.accepted       = f_acc;
        o_result.seq_out        = seq_out;
        o_result.index_now      = n_index;
        o_result.in_progress    = n_active;
        o_result.replay_clear   = f_clear;
        o_result.replay_reset   = f_reset;
        o_result.initiator_mark = f_init;
        o_result.deferred       = f_defer;
        o_result.state_changed  = f_changed;
        o_result.timer_on       = n_timer;
    end

endmodule

>>> design/iv_index_update_controller_unit.sv
// channel   direction  handshake                      payload
// in        request    i_in_valid / o_in_stall        i_in  (t_in_item)
// out       result     o_out_valid / i_out_stall      o_out (t_out_item)
// cfg       write      i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// one request per cycle sustained while results are not stalled; a taken request waits in
//   the input register, then its result in the result register, where o_out_valid shows it
// ivu_core writes its state registers on each fired request, so a request can follow every cycle
// synchronous active-low reset clears state and valids, config goes to its defaults
// input register and output register decouple the sides: a request is taken while
//   a finished result still waits, stall only rises when both stages are full
module iv_index_update_controller_unit
    import ivu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_item result;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic      in_take;
    logic      fire;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    ivu_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // the held request is processed when the output register is free or draining
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    ivu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // control valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> design/ivu_checker.sv
module ivu_checker
    import ivu_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed under stall");

    // no result appears right out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // entering update mode is a completed state change with the timer armed
    a_enter_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.replay_reset |->
            o_out.accepted && o_out.in_progress && o_out.timer_on && o_out.state_changed)
        else $error("update entry without full state change");

    // recovery always completes
    a_recovery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.replay_clear |-> o_out.accepted && o_out.state_changed)
        else $error("recovery without state change");

    // a deferral leaves update mode in place
    a_defer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.deferred |-> !o_out.accepted && o_out.in_progress)
        else $error("deferral changed state");

endmodule

bind iv_index_update_controller_unit ivu_checker u_ivu_checker (.*);

>>> tb/tb_iv_index_update_controller_unit.sv
module tb_iv_index_update_controller_unit;
    import ivu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          HOLD_CYCLES    = 60;
    localparam logic [31:0] WINDOW         = 32'd42;
    localparam logic [8:0]  HOUR_CAP       = 9'd255;
    // opcodes the block ignores
    localparam logic [2:0]  OP_SPARE_LOW   = 3'd5;
    localparam logic [2:0]  OP_SPARE_HIGH  = 3'd7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [2:0]            i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    iv_index_update_controller_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // requests waiting to be offered, status reports waiting to come back
    t_in_item    req_q[$];
    t_out_item   status_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          hold_cmds     = 0;
    int          hold_taken    = 0;
    int          hold_left     = 0;
    int          mismatches    = 0;
    int          cycles        = 0;

    // generator's guess of the current index, resynced by every load it emits
    logic [31:0] gen_base = '0;

    // shadow of the configuration registers, reset values
    logic [7:0]  c_min_hours      = 8'd96;
    logic [7:0]  c_hours_per_tick = 8'd24;
    logic [23:0] c_seq_limit      = 24'd8000000;
    logic        c_bypass         = 1'b0;
    logic        c_primary        = 1'b1;

    // predicted controller state
    logic [31:0] iv_cur_index;
    logic        iv_active;
    logic [7:0]  iv_hours;
    logic [23:0] iv_seq;
    logic        iv_pending;
    logic        iv_armed;

    // side requests raised by the event being predicted
    logic r_clear, r_reset, r_init, r_defer, r_changed;

    // one attempt to move between normal and update mode
    function automatic logic iv_try_move(logic [31:0] idx, logic flag, logic busy);
        logic [31:0] hi;
        logic [31:0] nxt;
        logic        recovered;
        hi        = iv_cur_index + WINDOW;
        nxt       = iv_cur_index + 32'd1;
        recovered = 1'b0;
        if (iv_active) begin
            if (idx != iv_cur_index || flag)
                return 1'b0;
        end else begin
            if (idx == iv_cur_index)
                return 1'b0;
            if (idx < iv_cur_index || idx > hi)
                return 1'b0;
            if (idx > nxt) begin
                // index recovery: jump at once, no duration check
                r_clear      = 1'b1;
                iv_cur_index = idx;
                iv_seq       = '0;
                recovered    = 1'b1;
            end else if (!flag) begin
                return 1'b0;
            end
        end
        if (!recovered) begin
            if (!c_bypass && iv_hours < c_min_hours)
                return 1'b0;
            if (!flag && busy) begin
                // return to normal waits for outstanding segmented transfers
                iv_pending = 1'b1;
                r_defer    = 1'b1;
                return 1'b0;
            end
        end
        iv_active = flag;
        iv_hours  = '0;
        if (flag) begin
            iv_cur_index = idx;
            r_reset      = 1'b1;
        end else begin
            iv_seq = '0;
        end
        iv_armed  = 1'b1;
        r_changed = 1'b1;
        return 1'b1;
    endfunction

    // applies one request to the predicted state, returns its status report
    function automatic t_out_item iv_event_outcome(t_in_item req);
        t_out_item   res;
        logic [8:0]  sum;
        logic [23:0] issued;
        logic        acc;
        r_clear   = 1'b0;
        r_reset   = 1'b0;
        r_init    = 1'b0;
        r_defer   = 1'b0;
        r_changed = 1'b0;
        acc       = 1'b0;
        issued    = iv_seq;
        case (req.opcode)
            OP_TICK: begin
                // an unarmed timer cannot expire
                if (iv_armed) begin
                    sum      = {1'b0, iv_hours} + {1'b0, c_hours_per_tick};
                    iv_armed = 1'b0;
                    iv_hours = (sum > HOUR_CAP) ? HOUR_CAP[7:0] : sum[7:0];
                    if (iv_hours < c_min_hours) begin
                        iv_armed = 1'b1;
                    end else if (iv_active) begin
                        r_init = 1'b1;
                        acc    = iv_try_move(iv_cur_index, 1'b0, req.tx_busy);
                    end
                end
            end
            OP_RX: begin
                acc = iv_try_move(req.new_index, req.update_flag, req.tx_busy);
            end
            OP_ALLOC: begin
                issued = iv_seq;
                iv_seq = iv_seq + 24'd1;
                if (!iv_active && iv_seq > c_seq_limit && c_primary) begin
                    r_init = 1'b1;
                    acc    = iv_try_move(iv_cur_index + 32'd1, 1'b1, req.tx_busy);
                end
            end
            OP_LOAD: begin
                iv_cur_index = req.new_index;
                iv_active    = req.update_flag;
                iv_hours     = req.load_hours;
                iv_seq       = req.load_seq;
                if (iv_hours < c_min_hours)
                    iv_armed = 1'b1;
                acc = 1'b1;
            end
            OP_TOGGLE: begin
                if (iv_active)
                    acc = iv_try_move(iv_cur_index, 1'b0, req.tx_busy);
                else
                    acc = iv_try_move(iv_cur_index + 32'd1, 1'b1, req.tx_busy);
            end
            default: ;
        endcase
        if (req.opcode != OP_ALLOC)
            issued = iv_seq;
        res.accepted       = acc;
        res.seq_out        = issued;
        res.index_now      = iv_cur_index;
        res.in_progress    = iv_active;
        res.replay_clear   = r_clear;
        res.replay_reset   = r_reset;
        res.initiator_mark = r_init;
        res.deferred       = r_defer;
        res.state_changed  = r_changed;
        res.timer_on       = iv_armed;
        return res;
    endfunction

    function automatic void match_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
            mismatches++;
        end
    endfunction

    function automatic void check_status(t_out_item want, t_out_item seen);
        match_field("accepted", 32'(want.accepted), 32'(seen.accepted));
        match_field("seq_out", 32'(want.seq_out), 32'(seen.seq_out));
        match_field("index_now", want.index_now, seen.index_now);
        match_field("in_progress", 32'(want.in_progress), 32'(seen.in_progress));
        match_field("replay_clear", 32'(want.replay_clear), 32'(seen.replay_clear));
        match_field("replay_reset", 32'(want.replay_reset), 32'(seen.replay_reset));
        match_field("initiator_mark", 32'(want.initiator_mark), 32'(seen.initiator_mark));
        match_field("deferred", 32'(want.deferred), 32'(seen.deferred));
        match_field("state_changed", 32'(want.state_changed), 32'(seen.state_changed));
        match_field("timer_on", 32'(want.timer_on), 32'(seen.timer_on));
    endfunction

    function automatic t_in_item compose_request(logic [2:0] op, logic [31:0] idx, logic flag,
                                                 logic busy, logic [7:0] hours,
                                                 logic [23:0] seq);
        t_in_item r;
        r.opcode      = op;
        r.new_index   = idx;
        r.update_flag = flag;
        r.tx_busy     = busy;
        r.load_hours  = hours;
        r.load_seq    = seq;
        return r;
    endfunction

    // mostly well-formed traffic around the current index, some noise
    function automatic t_in_item random_request();
        t_in_item    r;
        int unsigned pick;
        pick          = $urandom_range(99);
        r.opcode      = OP_TICK;
        r.new_index   = $urandom;
        r.update_flag = 1'($urandom_range(1));
        r.tx_busy     = ($urandom_range(3) == 0);
        r.load_hours  = 8'($urandom);
        r.load_seq    = 24'($urandom);
        if (pick < 24) begin
            r.opcode = OP_TICK;
        end else if (pick < 54) begin
            r.opcode = OP_RX;
            case ($urandom_range(6))
                0: r.new_index = gen_base;
                1: r.new_index = gen_base + 32'd1;
                2: r.new_index = gen_base + 32'($urandom_range(42, 2));
                3: r.new_index = gen_base + 32'($urandom_range(44, 42));
                4: r.new_index = gen_base - 32'd1;
                5: r.new_index = gen_base + 32'($urandom_range(3));
                default: ;
            endcase
        end else if (pick < 68) begin
            r.opcode = OP_ALLOC;
        end else if (pick < 80) begin
            r.opcode = OP_TOGGLE;
        end else if (pick < 96) begin
            r.opcode = OP_LOAD;
            case ($urandom_range(9))
                0: r.new_index = 32'hFFFF_FFFF - 32'($urandom_range(45));
                1: ;
                default: r.new_index = gen_base + 32'($urandom_range(3));
            endcase
            gen_base = r.new_index;
            if ($urandom_range(1) == 0)
                r.load_hours = c_min_hours + 8'($urandom_range(4)) - 8'd2;
            case ($urandom_range(4))
                0, 1: r.load_seq = c_seq_limit - 24'($urandom_range(3));
                2: r.load_seq = 24'hFF_FFFF - 24'($urandom_range(3));
                default: ;
            endcase
        end else begin
            r.opcode = 3'($urandom_range(OP_SPARE_HIGH, OP_SPARE_LOW));
        end
        return r;
    endfunction

    task automatic queue_random(int count);
        repeat (count) req_q.push_back(random_request());
    endtask

    task automatic cfg_write(t_cfg_index idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_HOURS:       c_min_hours      = data[7:0];
            CFG_HOURS_PER_TICK:  c_hours_per_tick = data[7:0];
            CFG_SEQ_LIMIT:       c_seq_limit      = data[23:0];
            CFG_TEST_BYPASS:     c_bypass         = data[0];
            CFG_PRIMARY_PRESENT: c_primary        = data[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [7:0] min_h, logic [7:0] per_tick, logic [23:0] limit,
                                 logic bypass, logic primary);
        cfg_write(CFG_MIN_HOURS, 24'(min_h));
        cfg_write(CFG_HOURS_PER_TICK, 24'(per_tick));
        cfg_write(CFG_SEQ_LIMIT, limit);
        cfg_write(CFG_TEST_BYPASS, 24'(bypass));
        cfg_write(CFG_PRIMARY_PRESENT, 24'(primary));
    endtask

    // sender pauses until every queued request has reported back
    task automatic wait_drained();
        do @(posedge i_clk); while (req_q.size() != 0 || i_in_valid || status_q.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    // request driver, predicts each request at the edge it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            iv_cur_index = '0;
            iv_active    = 1'b0;
            iv_hours     = '0;
            iv_seq       = '0;
            iv_pending   = 1'b0;
            iv_armed     = 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                status_q.push_back(iv_event_outcome(i_in));
            // a stalled request stays put
            if (!i_in_valid || !o_in_stall) begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in       <= req_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    $display("%0t: status report with no request outstanding, actual %h",
                             $time, o_out);
                    mismatches++;
                end else begin
                    check_status(status_q.pop_front(), o_out);
                end
            end
            // long hold-off so the block backs up and stalls its input
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left   <= hold_left - 1;
            end else if (hold_taken != hold_cmds) begin
                i_out_stall <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                hold_taken  <= hold_taken + 1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 13;
        recv_idle_pct = 48;

        // directed: low seq limit and short minimum so every path is reachable
        apply_setting(8'd48, 8'd24, 24'd100, 1'b0, 1'b1);
        req_q.push_back(compose_request(OP_TICK, 32'h0, 1'b0, 1'b0, 8'h00, 24'h0));
        req_q.push_back(compose_request(OP_SPARE_HIGH, '1, 1'b1, 1'b1, 8'hFF, 24'hFF_FFFF));
        req_q.push_back(compose_request(OP_LOAD, 32'd1000, 1'b0, 1'b0, 8'd0, 24'd98));
        repeat (3) req_q.push_back(compose_request(OP_ALLOC, 32'h0, 1'b0, 1'b0, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_TICK, 32'h0, 1'b0, 1'b0, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_TICK, 32'h0, 1'b0, 1'b0, 8'h0, 24'h0));
        // normal to update on a beacon, then a repeated beacon
        req_q.push_back(compose_request(OP_RX, 32'd1001, 1'b1, 1'b0, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_RX, 32'd1001, 1'b1, 1'b0, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_TOGGLE, 32'h0, 1'b0, 1'b0, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_TICK, 32'h0, 1'b0, 1'b0, 8'h0, 24'h0));
        // expiry with transfers pending defers the return to normal
        req_q.push_back(compose_request(OP_TICK, 32'h0, 1'b0, 1'b1, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_TOGGLE, 32'h0, 1'b0, 1'b0, 8'h0, 24'h0));
        // recovery at the window edge, then just outside, below and plain +1
        req_q.push_back(compose_request(OP_RX, 32'd1043, 1'b0, 1'b0, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_RX, 32'd1086, 1'b0, 1'b0, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_RX, 32'd1042, 1'b1, 1'b0, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_RX, 32'd1044, 1'b0, 1'b0, 8'h0, 24'h0));
        // sequence wrap near the top of the index space
        req_q.push_back(compose_request(OP_LOAD, 32'hFFFF_FFF0, 1'b0, 1'b0, 8'hFF,
                                        24'hFF_FFFE));
        req_q.push_back(compose_request(OP_ALLOC, 32'h0, 1'b0, 1'b0, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_ALLOC, 32'h0, 1'b0, 1'b0, 8'h0, 24'h0));
        // index comparisons across the 32-bit wrap
        req_q.push_back(compose_request(OP_LOAD, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd200, 24'h0));
        req_q.push_back(compose_request(OP_RX, 32'd40, 1'b0, 1'b0, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_RX, 32'h0, 1'b1, 1'b1, 8'h0, 24'h0));
        req_q.push_back(compose_request(OP_TOGGLE, 32'h0, 1'b0, 1'b0, 8'h0, 24'h0));
        wait_drained();

        // reset-like setting, with a long receiver hold and a mid-phase pause
        apply_setting(8'd96, 8'd24, 24'd8000000, 1'b0, 1'b1);
        queue_random(60);
        hold_cmds++;
        wait_drained();
        queue_random(40);
        wait_drained();

        send_idle_pct = 48;
        recv_idle_pct = 13;

        // top extremes: saturating hours, limit never passed, bypass on
        apply_setting(8'd255, 8'd255, 24'hFF_FFFF, 1'b1, 1'b0);
        queue_random(100);
        wait_drained();

        // bottom extremes: no minimum, every allocation past the limit unless the sequence wraps to zero
        apply_setting(8'd0, 8'd1, 24'd0, 1'b0, 1'b1);
        queue_random(100);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;

        apply_setting(8'd10, 8'd3, 24'd500, 1'b0, 1'b1);
        queue_random(100);
        hold_cmds++;
        wait_drained();

        if (mismatches == 0 && status_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
